// ===== hdl/usbprs_pkg.sv =====
// Shared codes and reset values for the USB port reset sequencer.
`default_nettype none

package usbprs_pkg;

  // Sequence phases as reported on the phase field
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_DEBOUNCE = 3'd1;
  localparam logic [2:0] PH_RESET    = 3'd2;
  localparam logic [2:0] PH_DONE     = 3'd3;
  localparam logic [2:0] PH_ENABLED  = 3'd4;
  localparam logic [2:0] PH_FAILED   = 3'd5;

  // Reset kind written on drive_reset
  localparam logic [1:0] DRV_NONE  = 2'd0;
  localparam logic [1:0] DRV_PLAIN = 2'd1;
  localparam logic [1:0] DRV_WARM  = 2'd2;

  // Sequence outcomes
  localparam logic [3:0] OC_BUSY          = 4'd0;
  localparam logic [3:0] OC_SUCCESS       = 4'd1;
  localparam logic [3:0] OC_NOT_CONNECTED = 4'd2;
  localparam logic [3:0] OC_UNSTABLE      = 4'd3;
  localparam logic [3:0] OC_LOST          = 4'd4;
  localparam logic [3:0] OC_DISABLED      = 4'd5;
  localparam logic [3:0] OC_NOT_U0        = 4'd6;
  localparam logic [3:0] OC_SPEED_UNKNOWN = 4'd7;
  localparam logic [3:0] OC_NO_COMPLETION = 4'd8;
  localparam logic [3:0] OC_RESET_STUCK   = 4'd9;

  // Item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_POLL  = 1'b1;

  // Port status codes
  localparam logic [3:0] LINK_U0       = 4'd0;
  localparam logic [3:0] SPEED_UNKNOWN = 4'd0;

  // Register word indexes (byte address / 4)
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_SS_CODE  = 2'd2;

  localparam int          TICK_W           = 12;
  localparam int          ADDR_W           = 4;
  localparam int          DATA_W           = 32;
  localparam int          COUNTER_WIDTH_DEF = 12;
  localparam logic [11:0] DEBOUNCE_RST     = 12'd100;
  localparam logic [11:0] TIMEOUT_RST      = 12'd500;
  localparam logic [3:0]  SS_CODE_RST      = 4'd4;

  localparam logic [5:0] NO_FLAGS = 6'd0;

endpackage

`default_nettype wire

// ===== hdl/usb_port_reset_sequencer.sv =====
// Top level of the USB port reset sequencer: register port, state update, result register.
`default_nettype none
// The result word is registered: it is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the single state-update step between the input
//   handshake and the result register sets this, and input is held off only while
//   a result word is stalled at the output.
// Reset: synchronous rst returns the phase to idle, empties the result register and
//   loads the registers with debounce 100, timeout 500 and SuperSpeed code 4.

module usb_port_reset_sequencer
  import usbprs_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  // register port
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [ADDR_W-1:0]   paddr,
  input  wire  [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // input words
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 func,
  input  wire                 connected,
  input  wire                 connect_change,
  input  wire                 port_enabled,
  input  wire                 reset_active,
  input  wire                 warm_reset_active,
  input  wire                 reset_change,
  input  wire                 warm_reset_change,
  input  wire  [3:0]          link_state,
  input  wire  [3:0]          port_speed,
  input  wire  [5:0]          change_flags,
  // result words
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [2:0]          phase,
  output logic [1:0]          drive_reset,
  output logic [5:0]          clear_flags,
  output logic                finished,
  output logic [3:0]          outcome
);

  // Compare width wide enough for both the counters and the tick registers, so a
  // counter too narrow to reach a limit simply never meets it.
  localparam int CMP_W = (COUNTER_WIDTH > TICK_W) ? COUNTER_WIDTH : TICK_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  // Configuration registers
  logic [TICK_W-1:0] debounce_ticks;
  logic [TICK_W-1:0] timeout_ticks;
  logic [3:0]        super_speed_code;

  // Sequence state
  logic [2:0]               seq_phase, seq_phase_next;
  logic                     is_superspeed, is_superspeed_next;
  logic [COUNTER_WIDTH-1:0] stable_count, stable_count_next;
  logic [COUNTER_WIDTH-1:0] phase_elapsed, phase_elapsed_next;
  logic                     completion_seen, completion_seen_next;

  // Result of this word
  logic [2:0] phase_next;
  logic [1:0] drive_next;
  logic [5:0] clear_next;
  logic       finished_next;
  logic [3:0] outcome_next;

  logic                     accept;
  logic [COUNTER_WIDTH-1:0] elapsed_inc;
  logic [COUNTER_WIDTH-1:0] stable_inc;
  logic [TICK_W-1:0]        debounce_limit;
  logic                     rbit, cbit, comp_now;
  logic                     port_good;

  // ---------------------------------------------------------------------------
  // Register port: no wait states, writes land on the access phase.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RST;
      timeout_ticks    <= TIMEOUT_RST;
      super_speed_code <= SS_CODE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_DEBOUNCE: debounce_ticks   <= pwdata[TICK_W-1:0];
        REG_TIMEOUT:  timeout_ticks    <= pwdata[TICK_W-1:0];
        REG_SS_CODE:  super_speed_code <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DEBOUNCE: prdata = {{(DATA_W-TICK_W){1'b0}}, debounce_ticks};
      REG_TIMEOUT:  prdata = {{(DATA_W-TICK_W){1'b0}}, timeout_ticks};
      REG_SS_CODE:  prdata = {{(DATA_W-4){1'b0}}, super_speed_code};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: take a new word unless a result word is stuck at the output.
  // ---------------------------------------------------------------------------
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Saturating tick counters
  assign elapsed_inc = (phase_elapsed == CNT_MAX) ? phase_elapsed
                                                  : phase_elapsed + 1'b1;
  assign stable_inc  = (stable_count == CNT_MAX) ? stable_count
                                                 : stable_count + 1'b1;
  // A debounce limit of zero acts as one
  assign debounce_limit = (debounce_ticks == '0) ? TICK_W'(1) : debounce_ticks;

  // Pick the reset bits that belong to the chosen reset kind
  assign rbit      = is_superspeed ? warm_reset_active : reset_active;
  assign cbit      = is_superspeed ? warm_reset_change : reset_change;
  assign comp_now  = completion_seen || cbit;
  assign port_good = port_enabled && (link_state == LINK_U0) &&
                     (port_speed != SPEED_UNKNOWN);

  // ---------------------------------------------------------------------------
  // Sequence step: one pass per accepted word.
  // ---------------------------------------------------------------------------
  always_comb begin
    seq_phase_next       = seq_phase;
    is_superspeed_next   = is_superspeed;
    stable_count_next    = stable_count;
    phase_elapsed_next   = phase_elapsed;
    completion_seen_next = completion_seen;
    drive_next           = DRV_NONE;
    clear_next           = NO_FLAGS;
    finished_next        = 1'b0;
    outcome_next         = OC_BUSY;

    if (func == FUNC_START) begin
      // A start always restarts the sequence counters and clears stale changes
      stable_count_next    = '0;
      phase_elapsed_next   = '0;
      completion_seen_next = 1'b0;
      clear_next           = change_flags;
      if (!connected) begin
        seq_phase_next = PH_FAILED;
        finished_next  = 1'b1;
        outcome_next   = OC_NOT_CONNECTED;
      end else begin
        is_superspeed_next = (port_speed == super_speed_code);
        seq_phase_next     = PH_DEBOUNCE;
      end
    end else begin
      case (seq_phase)
        PH_DEBOUNCE: begin
          clear_next        = {5'd0, connect_change};
          // Restart the stable count on a drop or a connect change
          stable_count_next = (!connected || connect_change) ? '0 : stable_inc;
          if (CMP_W'(stable_count_next) >= CMP_W'(debounce_limit)) begin
            seq_phase_next       = PH_RESET;
            phase_elapsed_next   = '0;
            completion_seen_next = 1'b0;
            drive_next           = is_superspeed ? DRV_WARM : DRV_PLAIN;
          end else begin
            phase_elapsed_next = elapsed_inc;
            if (CMP_W'(elapsed_inc) >= CMP_W'(timeout_ticks)) begin
              seq_phase_next = PH_FAILED;
              clear_next     = change_flags;
              finished_next  = 1'b1;
              outcome_next   = OC_UNSTABLE;
            end
          end
        end
        PH_RESET, PH_DONE: begin
          if (!connected) begin
            seq_phase_next = PH_FAILED;
            clear_next     = change_flags;
            finished_next  = 1'b1;
            outcome_next   = OC_LOST;
          end else begin
            completion_seen_next = comp_now;
            if (cbit && !completion_seen) begin
              seq_phase_next = PH_DONE;
            end
            if (comp_now && !rbit && port_good) begin
              seq_phase_next = PH_ENABLED;
              clear_next     = change_flags;
              finished_next  = 1'b1;
              outcome_next   = OC_SUCCESS;
            end else begin
              phase_elapsed_next = elapsed_inc;
              if (CMP_W'(elapsed_inc) >= CMP_W'(timeout_ticks)) begin
                // Out of polls: report the first check that still fails
                seq_phase_next = PH_FAILED;
                clear_next     = change_flags;
                finished_next  = 1'b1;
                if (!comp_now) begin
                  outcome_next = OC_NO_COMPLETION;
                end else if (rbit) begin
                  outcome_next = OC_RESET_STUCK;
                end else if (!port_enabled) begin
                  outcome_next = OC_DISABLED;
                end else if (link_state != LINK_U0) begin
                  outcome_next = OC_NOT_U0;
                end else begin
                  outcome_next = OC_SPEED_UNKNOWN;
                end
              end
            end
          end
        end
        default: ;  // idle, enabled, failed: polls change nothing
      endcase
    end

    phase_next = seq_phase_next;
  end

  // ---------------------------------------------------------------------------
  // State and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase       <= PH_IDLE;
      is_superspeed   <= 1'b0;
      stable_count    <= '0;
      phase_elapsed   <= '0;
      completion_seen <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        seq_phase       <= seq_phase_next;
        is_superspeed   <= is_superspeed_next;
        stable_count    <= stable_count_next;
        phase_elapsed   <= phase_elapsed_next;
        completion_seen <= completion_seen_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        // Drop the result once it has been taken
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load only with a new word, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      phase       <= phase_next;
      drive_reset <= drive_next;
      clear_flags <= clear_next;
      finished    <= finished_next;
      outcome     <= outcome_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word produced no result");

  a_start_unconnected_fails: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && func == FUNC_START && !connected) |=>
      (phase == PH_FAILED && outcome == OC_NOT_CONNECTED && finished))
    else $error("start without device did not fail");

  a_drive_only_on_reset_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_reset != DRV_NONE) |->
      (phase == PH_RESET && !finished && seq_phase == PH_RESET))
    else $error("reset driven outside reset entry");

  a_finished_is_terminal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |->
      ((phase == PH_ENABLED || phase == PH_FAILED) && outcome != OC_BUSY))
    else $error("finished result with non-terminal phase");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the USB port reset sequencer with a result scoreboard.

import usbprs_pkg::*;

// One input word, in port order
typedef struct packed {
  logic       func;
  logic       connected;
  logic       connect_change;
  logic       port_enabled;
  logic       reset_active;
  logic       warm_reset_active;
  logic       reset_change;
  logic       warm_reset_change;
  logic [3:0] link_state;
  logic [3:0] port_speed;
  logic [5:0] change_flags;
} port_status_t;

// One result word, in port order
typedef struct packed {
  logic [2:0] phase;
  logic [1:0] drive_reset;
  logic [5:0] clear_flags;
  logic       finished;
  logic [3:0] outcome;
} port_report_t;

localparam logic [5:0] FLAG_CSC      = 6'b000001;
localparam logic [11:0] TICK_MAX     = 12'hFFF;

class reset_scoreboard;
  // register copies
  logic [11:0] debounce_lim;
  logic [11:0] timeout_lim;
  logic [3:0]  ss_code;
  // sequencer state
  logic [2:0]  seq_phase;
  logic        superspeed;
  logic [11:0] stable_cnt;
  logic [11:0] elapsed;
  logic        completion_seen;

  port_report_t awaited_reports[$];
  int failures;
  int words;
  int outcome_hits[16];

  function new();
    debounce_lim    = DEBOUNCE_RST;
    timeout_lim     = TIMEOUT_RST;
    ss_code         = SS_CODE_RST;
    seq_phase       = PH_IDLE;
    superspeed      = 1'b0;
    stable_cnt      = '0;
    elapsed         = '0;
    completion_seen = 1'b0;
    failures        = 0;
    words           = 0;
    foreach (outcome_hits[i]) outcome_hits[i] = 0;
  endfunction

  function void write_register(logic [1:0] idx, logic [31:0] value);
    case (idx)
      REG_DEBOUNCE: debounce_lim = value[11:0];
      REG_TIMEOUT:  timeout_lim  = value[11:0];
      REG_SS_CODE:  ss_code      = value[3:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] register_value(logic [1:0] idx);
    case (idx)
      REG_DEBOUNCE: return {20'd0, debounce_lim};
      REG_TIMEOUT:  return {20'd0, timeout_lim};
      REG_SS_CODE:  return {28'd0, ss_code};
      default:      return '0;
    endcase
  endfunction

  // Saturating tick counter
  function logic [11:0] bump(logic [11:0] v);
    return (v == TICK_MAX) ? v : v + 12'd1;
  endfunction

  function port_report_t report(logic [1:0] drv, logic [5:0] clr, logic fin,
                                logic [3:0] oc);
    port_report_t r;
    r.phase       = seq_phase;
    r.drive_reset = drv;
    r.clear_flags = clr;
    r.finished    = fin;
    r.outcome     = oc;
    return r;
  endfunction

  function port_report_t end_failed(logic [3:0] code, logic [5:0] flags);
    seq_phase = PH_FAILED;
    return report(DRV_NONE, flags, 1'b1, code);
  endfunction

  function port_report_t advance_sequence(port_status_t s);
    logic        rbit;
    logic        cbit;
    logic [11:0] dlim;
    logic [3:0]  code;
    logic [5:0]  clr;
    if (s.func == FUNC_START) begin
      stable_cnt      = '0;
      elapsed         = '0;
      completion_seen = 1'b0;
      if (!s.connected) return end_failed(OC_NOT_CONNECTED, s.change_flags);
      superspeed = (s.port_speed == ss_code);
      seq_phase  = PH_DEBOUNCE;
      return report(DRV_NONE, s.change_flags, 1'b0, OC_BUSY);
    end
    if (seq_phase == PH_DEBOUNCE) begin
      clr     = s.connect_change ? FLAG_CSC : NO_FLAGS;
      elapsed = bump(elapsed);
      if (!s.connected || s.connect_change) stable_cnt = '0;
      else stable_cnt = bump(stable_cnt);
      dlim = (debounce_lim == 12'd0) ? 12'd1 : debounce_lim;
      // the stable limit wins over the timeout on the same tick
      if (stable_cnt >= dlim) begin
        seq_phase       = PH_RESET;
        elapsed         = '0;
        completion_seen = 1'b0;
        return report(superspeed ? DRV_WARM : DRV_PLAIN, clr, 1'b0, OC_BUSY);
      end
      if (elapsed >= timeout_lim) return end_failed(OC_UNSTABLE, s.change_flags);
      return report(DRV_NONE, clr, 1'b0, OC_BUSY);
    end
    if (seq_phase == PH_RESET || seq_phase == PH_DONE) begin
      if (!s.connected) return end_failed(OC_LOST, s.change_flags);
      rbit = superspeed ? s.warm_reset_active : s.reset_active;
      cbit = superspeed ? s.warm_reset_change : s.reset_change;
      if (cbit && !completion_seen) begin
        completion_seen = 1'b1;
        seq_phase       = PH_DONE;
      end
      if (completion_seen && !rbit && s.port_enabled && s.link_state == LINK_U0 &&
          s.port_speed != SPEED_UNKNOWN) begin
        seq_phase = PH_ENABLED;
        return report(DRV_NONE, s.change_flags, 1'b1, OC_SUCCESS);
      end
      elapsed = bump(elapsed);
      if (elapsed >= timeout_lim) begin
        if (!completion_seen) code = OC_NO_COMPLETION;
        else if (rbit) code = OC_RESET_STUCK;
        else if (!s.port_enabled) code = OC_DISABLED;
        else if (s.link_state != LINK_U0) code = OC_NOT_U0;
        else code = OC_SPEED_UNKNOWN;
        return end_failed(code, s.change_flags);
      end
      return report(DRV_NONE, NO_FLAGS, 1'b0, OC_BUSY);
    end
    // idle, enabled or failed: a poll changes nothing
    return report(DRV_NONE, NO_FLAGS, 1'b0, OC_BUSY);
  endfunction

  function void note_word(port_status_t s);
    port_report_t r;
    r = advance_sequence(s);
    words++;
    if (r.finished) outcome_hits[r.outcome]++;
    awaited_reports.push_back(r);
  endfunction

  function void compare_field(string name, logic [5:0] want, logic [5:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  function void check_report(port_report_t got);
    port_report_t want;
    if (awaited_reports.size() == 0) begin
      $display("%0t: result word with none expected, actual %p", $time, got);
      failures++;
      return;
    end
    want = awaited_reports.pop_front();
    compare_field("phase", want.phase, got.phase);
    compare_field("drive_reset", want.drive_reset, got.drive_reset);
    compare_field("clear_flags", want.clear_flags, got.clear_flags);
    compare_field("finished", want.finished, got.finished);
    compare_field("outcome", want.outcome, got.outcome);
  endfunction
endclass

module testbench;
  localparam int RUN_LIMIT     = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PCT      = 31;

  logic              clk;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  wire  [DATA_W-1:0] prdata;
  wire               pready;
  logic              in_valid = 1'b0;
  wire               in_stall;
  port_status_t      word_in  = '0;
  wire               out_valid;
  logic              out_stall = 1'b0;
  wire  [2:0]        phase;
  wire  [1:0]        drive_reset;
  wire  [5:0]        clear_flags;
  wire               finished;
  wire  [3:0]        outcome;

  // receiver and sender controls, driven from the stimulus process
  logic rx_quiet = 1'b0;
  logic hold_req = 1'b0;
  bit   tx_quiet = 1'b0;

  int cycles   = 0;
  int settings = 0;
  reset_scoreboard sb;

  usb_port_reset_sequencer dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (word_in.func),
    .connected        (word_in.connected),
    .connect_change   (word_in.connect_change),
    .port_enabled     (word_in.port_enabled),
    .reset_active     (word_in.reset_active),
    .warm_reset_active(word_in.warm_reset_active),
    .reset_change     (word_in.reset_change),
    .warm_reset_change(word_in.warm_reset_change),
    .link_state       (word_in.link_state),
    .port_speed       (word_in.port_speed),
    .change_flags     (word_in.change_flags),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .phase            (phase),
    .drive_reset      (drive_reset),
    .clear_flags      (clear_flags),
    .finished         (finished),
    .outcome          (outcome)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: check each accepted result word, then pick the stall for the next
  // cycle. One long hold-off, counted here, backs the block up into its input.
  initial begin : receiver
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        sb.check_report({phase, drive_reset, clear_flags, finished, outcome});
      if (hold_req && !hold_used) begin
        hold_used = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= rx_quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // One register access: setup cycle, access cycle, then an idle gap so the
  // next access never lands in the same step. Reads compare with the copy.
  task automatic apb_transfer(logic write, logic [1:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (write) begin
      sb.write_register(idx, value);
    end else if (prdata !== sb.register_value(idx)) begin
      $display("%0t: register %0d readback, expected %0h, actual %0h", $time, idx,
               sb.register_value(idx), prdata);
      sb.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write with junk in the unused upper bits, then read it back
  task automatic program_register(logic [1:0] idx, logic [31:0] value);
    logic [31:0] junk;
    junk = $urandom;
    junk[15:0] = '0;
    apb_transfer(1'b1, idx, value | junk);
    apb_transfer(1'b0, idx, '0);
  endtask

  task automatic apply_settings(int debounce, int timeout, int ss);
    program_register(REG_DEBOUNCE, debounce);
    program_register(REG_TIMEOUT, timeout);
    program_register(REG_SS_CODE, ss);
    settings++;
  endtask

  // Offer one word, maybe after a short gap; hold it until accepted
  task automatic send_word(port_status_t w);
    if (!tx_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    word_in  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  // Drop valid and wait until every result word is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic port_status_t make_status(logic fn, logic conn, logic csc, logic ped,
                                               logic pr, logic wpr, logic prc, logic wrc,
                                               logic [3:0] ls, logic [3:0] spd,
                                               logic [5:0] flags);
    return {fn, conn, csc, ped, pr, wpr, prc, wrc, ls, spd, flags};
  endfunction

  // Build the next word from the predicted phase: mostly well-formed sequences
  // with random content, a little pure noise and an occasional restart.
  function automatic port_status_t next_word();
    port_status_t w;
    logic [31:0]  noise;
    logic         rbit;
    logic         cbit;
    noise = $urandom;
    w = noise[$bits(port_status_t)-1:0];
    if ($urandom_range(0, 99) < 5) return w;
    case (sb.seq_phase)
      PH_DEBOUNCE: begin
        w.func           = ($urandom_range(0, 99) < 2) ? FUNC_START : FUNC_POLL;
        w.connected      = ($urandom_range(0, 99) < 94);
        w.connect_change = ($urandom_range(0, 99) < 6);
      end
      PH_RESET, PH_DONE: begin
        w.func      = ($urandom_range(0, 99) < 2) ? FUNC_START : FUNC_POLL;
        w.connected = ($urandom_range(0, 99) < 97);
        rbit        = ($urandom_range(0, 99) < 35);
        cbit        = ($urandom_range(0, 99) < 35);
        if (sb.superspeed) begin
          w.warm_reset_active = rbit;
          w.warm_reset_change = cbit;
        end else begin
          w.reset_active = rbit;
          w.reset_change = cbit;
        end
        w.port_enabled = ($urandom_range(0, 99) < 88);
        if ($urandom_range(0, 99) < 80) w.link_state = LINK_U0;
        if ($urandom_range(0, 99) < 85) w.port_speed = 4'($urandom_range(1, 15));
      end
      default: begin
        w.func      = ($urandom_range(0, 99) < 10) ? FUNC_POLL : FUNC_START;
        w.connected = ($urandom_range(0, 99) < 92);
        if ($urandom_range(0, 99) < 50) w.port_speed = sb.ss_code;
      end
    endcase
    return w;
  endfunction

  // Send random words until n of them did something, then drain
  task automatic run_phase(int n);
    port_status_t w;
    int           left;
    bit           ignored;
    left = n;
    while (left > 0) begin
      w = next_word();
      ignored = (w.func == FUNC_POLL) && (sb.seq_phase == PH_IDLE ||
                sb.seq_phase == PH_ENABLED || sb.seq_phase == PH_FAILED);
      send_word(w);
      if (!ignored) left--;
    end
    drain();
  endtask

  initial begin : stimulus
    int seen;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers come out of reset with their defaults
    apb_transfer(1'b0, REG_DEBOUNCE, '0);
    apb_transfer(1'b0, REG_TIMEOUT, '0);
    apb_transfer(1'b0, REG_SS_CODE, '0);

    // Directed: debounce 2, timeout 3, warm reset on speed 4
    apply_settings(2, 3, 4);
    // poll while idle is ignored; start with nothing connected fails at once
    send_word(make_status(FUNC_POLL, 1, 1, 1, 1, 1, 1, 1, 4'hF, 4'hF, 6'h3F));
    send_word(make_status(FUNC_START, 0, 1, 1, 1, 1, 1, 1, 4'hF, 4'hF, 6'h3F));
    send_word(make_status(FUNC_POLL, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h0, 6'h00));
    // warm path: connect change restarts the count, stable limit beats timeout
    send_word(make_status(FUNC_START, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h4, 6'h2A));
    send_word(make_status(FUNC_POLL, 1, 1, 0, 0, 0, 0, 0, 4'h0, 4'h4, 6'h00));
    send_word(make_status(FUNC_POLL, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h4, 6'h00));
    send_word(make_status(FUNC_POLL, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h4, 6'h00));
    send_word(make_status(FUNC_POLL, 1, 0, 1, 0, 1, 0, 0, 4'h0, 4'h4, 6'h00));
    send_word(make_status(FUNC_POLL, 1, 0, 1, 0, 0, 0, 1, 4'h0, 4'hF, 6'h3F));
    // poll after success is ignored
    send_word(make_status(FUNC_POLL, 1, 1, 1, 1, 1, 1, 1, 4'hF, 4'hF, 6'h3F));
    // plain path: completion seen but reset bit stuck until timeout
    send_word(make_status(FUNC_START, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h3, 6'h15));
    send_word(make_status(FUNC_POLL, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h3, 6'h00));
    send_word(make_status(FUNC_POLL, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h3, 6'h00));
    send_word(make_status(FUNC_POLL, 1, 0, 1, 1, 0, 1, 0, 4'h0, 4'h3, 6'h00));
    send_word(make_status(FUNC_POLL, 1, 0, 1, 1, 0, 0, 0, 4'h0, 4'h3, 6'h00));
    send_word(make_status(FUNC_POLL, 1, 0, 0, 1, 0, 0, 0, 4'h0, 4'h3, 6'h0C));
    // disconnected through the whole debounce window: unstable
    send_word(make_status(FUNC_START, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h1, 6'h00));
    send_word(make_status(FUNC_POLL, 0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h1, 6'h01));
    send_word(make_status(FUNC_POLL, 0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h1, 6'h01));
    send_word(make_status(FUNC_POLL, 0, 0, 0, 0, 0, 0, 0, 4'h0, 4'h1, 6'h01));
    // restart while busy, then lose the device during reset
    send_word(make_status(FUNC_START, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h2, 6'h00));
    send_word(make_status(FUNC_START, 1, 1, 0, 0, 0, 0, 0, 4'h0, 4'h2, 6'h30));
    send_word(make_status(FUNC_POLL, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h2, 6'h00));
    send_word(make_status(FUNC_POLL, 1, 0, 0, 0, 0, 0, 0, 4'h0, 4'h2, 6'h00));
    send_word(make_status(FUNC_POLL, 0, 0, 1, 1, 1, 1, 1, 4'hA, 4'h2, 6'h3F));
    drain();

    // Random phases; the first one also carries the long receiver hold-off
    apply_settings(3, 8, 4);
    hold_req <= 1'b1;
    run_phase(200);
    apply_settings(1, 1, 0);
    run_phase(150);
    // zero limits: debounce acts as one, timeout ends every stage at once
    apply_settings(0, 0, 15);
    run_phase(120);
    apply_settings(4095, 6, 7);
    run_phase(120);
    apply_settings(2, 4095, 3);
    run_phase(200);
    // back-to-back stretch with no idling on either side
    tx_quiet = 1'b1;
    rx_quiet <= 1'b1;
    apply_settings(4, 4, $urandom_range(0, 15));
    run_phase(250);
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
    repeat (3) begin
      apply_settings($urandom_range(1, 6), $urandom_range(1, 24), $urandom_range(0, 15));
      run_phase(170);
    end

    seen = 0;
    for (int i = OC_SUCCESS; i <= OC_RESET_STUCK; i++)
      if (sb.outcome_hits[i] != 0) seen++;
    $display("Covered %0d words over %0d register settings.", sb.words, settings);
    $display("Sequences ended: %0d succeeded, %0d of 9 outcome codes reached.",
             sb.outcome_hits[OC_SUCCESS], seen);
    if (sb.awaited_reports.size() != 0)
      $display("%0t: %0d result words never arrived", $time, sb.awaited_reports.size());
    if (sb.failures == 0 && sb.awaited_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
